### sv/uart_rx_tx_ring_buffers_assert.svh
// Assertion macros for the UART ring buffer block.
// Included by the RTL modules that check their own logic; needs no package.
`ifndef UART_RX_TX_RING_BUFFERS_ASSERT_SVH
`define UART_RX_TX_RING_BUFFERS_ASSERT_SVH
`ifndef SYNTH
`define URB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ring buffer check failed");
`define URB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ring buffer check failed");
`else
`define URB_ASSERT_NOW(label, clk, rst, ante, cons)
`define URB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### sv/uartrb_pkg.sv
// Types shared by the UART ring buffer block: operation codes and beat payloads.
// No dependencies.
package uartrb_pkg;

   typedef enum logic [1:0] {
      OP_LINE  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef struct packed {
      op_type     operation;
      logic       rx_ready;
      logic [7:0] rx_byte;
      logic       line_error;
      logic       tx_empty;
      logic [7:0] host_byte;
   } req_type;

   typedef struct packed {
      logic        tx_send;
      logic [7:0]  tx_byte;
      logic        read_valid;
      logic [7:0]  read_byte;
      logic        rx_has_data;
      logic        write_accepted;
      logic [15:0] error_count;
      logic        error_led;
      logic        tx_irq_enable;
   } rsp_type;

   localparam logic [15:0] ERR_MAX = 16'hFFFF;

endpackage

### sv/uart_rx_tx_ring_buffers.sv
// UART receive and transmit ring buffers with error tally, top level.
// Depends on uartrb_pkg and uart_rx_tx_ring_buffers_assert.svh.
//
// Takes one request beat per cycle and returns exactly one response beat per
// request, in the next cycle, through an output register; request stall rises
// only while that register is full and stalled. Each ring is a single memory
// with one write and one registered read per cycle, and no request touches
// both ports of one ring. Each ring holds depth-1 bytes. Store contents are
// not cleared at reset: only written entries are ever read.
module uart_rx_tx_ring_buffers #(
   parameter int RX_DEPTH = 512,
   parameter int TX_DEPTH = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  uartrb_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output uartrb_pkg::rsp_type rsp_data
);

   localparam int RX_AW = $clog2(RX_DEPTH);
   localparam int TX_AW = $clog2(TX_DEPTH);

   logic [7:0] rx_mem [RX_DEPTH];
   logic [7:0] tx_mem [TX_DEPTH];

   logic [RX_AW-1:0] rx_wr_ptr_ff, rx_wr_ptr_in, rx_rd_ptr_ff, rx_rd_ptr_in, rx_wr_next;
   logic [TX_AW-1:0] tx_wr_ptr_ff, tx_wr_ptr_in, tx_rd_ptr_ff, tx_rd_ptr_in, tx_wr_next;
   logic [15:0]      tally_ff, tally_in;
   logic [16:0]      err_sum;
   logic             led_ff, led_in, irq_ff, irq_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rx_rd_data_ff, tx_rd_data_ff;
   uartrb_pkg::rsp_type rsp_ff, rsp_in;

   logic req_fire, rx_full, rx_ring_empty, tx_full, tx_ring_empty;
   logic rx_push, rx_pop, tx_push, tx_pop, overflow, wr_acc;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   assign rx_wr_next    = rx_wr_ptr_ff + 1'b1;
   assign tx_wr_next    = tx_wr_ptr_ff + 1'b1;
   assign rx_full       = (rx_wr_next == rx_rd_ptr_ff);
   assign tx_full       = (tx_wr_next == tx_rd_ptr_ff);
   assign rx_ring_empty = (rx_wr_ptr_ff == rx_rd_ptr_ff);
   assign tx_ring_empty = (tx_wr_ptr_ff == tx_rd_ptr_ff);

   always_comb begin
      rx_push  = 1'b0;
      rx_pop   = 1'b0;
      tx_push  = 1'b0;
      tx_pop   = 1'b0;
      overflow = 1'b0;
      wr_acc   = 1'b0;
      rx_wr_ptr_in = rx_wr_ptr_ff;
      rx_rd_ptr_in = rx_rd_ptr_ff;
      tx_wr_ptr_in = tx_wr_ptr_ff;
      tx_rd_ptr_in = tx_rd_ptr_ff;
      irq_in   = irq_ff;
      led_in   = led_ff;
      tally_in = tally_ff;
      err_sum  = 17'(tally_ff);
      if (req_fire) begin
         unique case (req_data.operation)
            uartrb_pkg::OP_LINE: begin
               rx_push  = req_data.rx_ready && !rx_full;
               overflow = req_data.rx_ready && rx_full;
               tx_pop   = req_data.tx_empty && !tx_ring_empty;
               if (req_data.tx_empty && tx_ring_empty) begin
                  irq_in = 1'b0;
               end
               err_sum  = 17'(tally_ff) + 17'(req_data.line_error) + 17'(overflow);
               tally_in = err_sum[16] ? uartrb_pkg::ERR_MAX : err_sum[15:0];
               led_in   = led_ff || (tally_in != 16'd0);
            end
            uartrb_pkg::OP_WRITE: begin
               tx_push = !tx_full;
               wr_acc  = !tx_full;
               if (!tx_full) begin
                  irq_in = 1'b1;
               end
            end
            uartrb_pkg::OP_READ: begin
               rx_pop = !rx_ring_empty;
            end
            uartrb_pkg::OP_CLEAR: begin
               rx_rd_ptr_in = rx_wr_ptr_ff;
            end
            default: begin
               rx_rd_ptr_in = rx_rd_ptr_ff;
            end
         endcase
      end
      if (rx_push) begin
         rx_wr_ptr_in = rx_wr_next;
      end
      if (rx_pop) begin
         rx_rd_ptr_in = rx_rd_ptr_ff + 1'b1;
      end
      if (tx_push) begin
         tx_wr_ptr_in = tx_wr_next;
      end
      if (tx_pop) begin
         tx_rd_ptr_in = tx_rd_ptr_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_in                = '0;
      rsp_in.tx_send        = tx_pop;
      rsp_in.read_valid     = rx_pop;
      rsp_in.rx_has_data    = (rx_rd_ptr_in != rx_wr_ptr_in);
      rsp_in.write_accepted = wr_acc;
      rsp_in.error_count    = tally_in;
      rsp_in.error_led      = led_in;
      rsp_in.tx_irq_enable  = irq_in;
      rsp_valid_in          = rsp_valid_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_in = req_fire;
      end
   end

   always_comb begin
      rsp_data           = rsp_ff;
      rsp_data.tx_byte   = rsp_ff.tx_send ? tx_rd_data_ff : 8'd0;
      rsp_data.read_byte = rsp_ff.read_valid ? rx_rd_data_ff : 8'd0;
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wr_ptr_ff <= '0;
         rx_rd_ptr_ff <= '0;
         tx_wr_ptr_ff <= '0;
         tx_rd_ptr_ff <= '0;
         tally_ff     <= '0;
         led_ff       <= 1'b0;
         irq_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rx_wr_ptr_ff <= rx_wr_ptr_in;
         rx_rd_ptr_ff <= rx_rd_ptr_in;
         tx_wr_ptr_ff <= tx_wr_ptr_in;
         tx_rd_ptr_ff <= tx_rd_ptr_in;
         tally_ff     <= tally_in;
         led_ff       <= led_in;
         irq_ff       <= irq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rx_push) begin
         rx_mem[rx_wr_ptr_ff] <= req_data.rx_byte;
      end
      if (rx_pop) begin
         rx_rd_data_ff <= rx_mem[rx_rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (tx_push) begin
         tx_mem[tx_wr_ptr_ff] <= req_data.host_byte;
      end
      if (tx_pop) begin
         tx_rd_data_ff <= tx_mem[tx_rd_ptr_ff];
      end
   end

`include "uart_rx_tx_ring_buffers_assert.svh"

   `URB_ASSERT_NOW(a_accept_sets_irq, clock, reset, rsp_valid_ff && rsp_ff.write_accepted, rsp_ff.tx_irq_enable)
   `URB_ASSERT_NEXT(a_clear_empties_rx, clock, reset, req_fire && req_data.operation == uartrb_pkg::OP_CLEAR, rx_rd_ptr_ff == rx_wr_ptr_ff)
   `URB_ASSERT_NEXT(a_led_sticky, clock, reset, led_ff, led_ff)
   `URB_ASSERT_NEXT(a_tally_saturates, clock, reset, tally_ff == uartrb_pkg::ERR_MAX, tally_ff == uartrb_pkg::ERR_MAX)

endmodule

### test/uart_rx_tx_ring_buffers_test.sv
// Self-checking bench for uart_rx_tx_ring_buffers: random and directed beats through
// valid/stall channels, each response checked against a ring-buffer predictor.
// Depends on uartrb_pkg and the uart_rx_tx_ring_buffers RTL.
module uart_rx_tx_ring_buffers_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RX_SLOTS = 512;
   localparam int TX_SLOTS = 128;
   localparam int RX_AW = $clog2(RX_SLOTS);
   localparam int TX_AW = $clog2(TX_SLOTS);
   localparam int PHASE_BEATS = 105;
   localparam int TAIL_READS = 24;
   localparam int HOLD_CYCLES = 60;
   localparam int DRAIN_CYCLES = 8;
   localparam int QUIET_LIMIT = 1000;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   uartrb_pkg::req_type req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   uartrb_pkg::rsp_type rsp_data;

   uartrb_pkg::req_type req_backlog[$];
   uartrb_pkg::rsp_type owed_rsp[$];
   bit      req_taken = 1'b0;
   bit      hold_req = 1'b0;
   int      hold_left = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      quiet_cycles = 0;
   int      mismatches = 0;
   int      beats_in = 0;
   int      beats_out = 0;
   int      refused_writes = 0;
   int      sends_seen = 0;

   // predictor state
   logic [7:0]       rx_copy[RX_SLOTS];
   logic [7:0]       tx_copy[TX_SLOTS];
   logic [RX_AW-1:0] rx_wr = '0, rx_rd = '0;
   logic [TX_AW-1:0] tx_wr = '0, tx_rd = '0;
   logic [15:0]      err_tally = '0;
   logic             led_on = 1'b0;
   logic             irq_on = 1'b0;

   uart_rx_tx_ring_buffers #(
      .RX_DEPTH(RX_SLOTS),
      .TX_DEPTH(TX_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic void bump_errors();
      if (err_tally != uartrb_pkg::ERR_MAX)
         err_tally = err_tally + 16'd1;
   endfunction

   function automatic uartrb_pkg::rsp_type ring_response(uartrb_pkg::req_type r);
      uartrb_pkg::rsp_type o;
      logic [RX_AW-1:0]    rx_next;
      logic [TX_AW-1:0]    tx_next;
      o = '0;
      case (r.operation)
         uartrb_pkg::OP_LINE: begin
            if (r.line_error)
               bump_errors();
            if (r.rx_ready) begin
               rx_next = rx_wr + 1'b1;
               if (rx_next != rx_rd) begin
                  rx_copy[rx_wr] = r.rx_byte;
                  rx_wr = rx_next;
               end else
                  bump_errors();
            end
            if (r.tx_empty) begin
               if (tx_rd != tx_wr) begin
                  o.tx_send = 1'b1;
                  o.tx_byte = tx_copy[tx_rd];
                  tx_rd = tx_rd + 1'b1;
               end else
                  irq_on = 1'b0;
            end
            if (err_tally != '0)
               led_on = 1'b1;
         end
         uartrb_pkg::OP_WRITE: begin
            tx_next = tx_wr + 1'b1;
            if (tx_next != tx_rd) begin
               tx_copy[tx_wr] = r.host_byte;
               tx_wr = tx_next;
               irq_on = 1'b1;
               o.write_accepted = 1'b1;
            end
         end
         uartrb_pkg::OP_READ: begin
            if (rx_rd != rx_wr) begin
               o.read_valid = 1'b1;
               o.read_byte = rx_copy[rx_rd];
               rx_rd = rx_rd + 1'b1;
            end
         end
         default:
            rx_rd = rx_wr;
      endcase
      o.rx_has_data = (rx_rd != rx_wr);
      o.error_count = err_tally;
      o.error_led = led_on;
      o.tx_irq_enable = irq_on;
      return o;
   endfunction

   function automatic uartrb_pkg::req_type make_beat(uartrb_pkg::op_type op, bit rdy,
                                                     logic [7:0] rxb, bit err,
                                                     bit txe, logic [7:0] hb);
      uartrb_pkg::req_type r;
      r.operation = op;
      r.rx_ready = rdy;
      r.rx_byte = rxb;
      r.line_error = err;
      r.tx_empty = txe;
      r.host_byte = hb;
      return r;
   endfunction

   function automatic uartrb_pkg::req_type random_beat();
      uartrb_pkg::req_type r;
      int                  pick;
      pick = int'($urandom_range(99));
      r = make_beat(uartrb_pkg::OP_LINE, 1'($urandom_range(1)), 8'($urandom_range(255)),
                    1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)));
      if (pick >= 96)
         r.operation = uartrb_pkg::OP_CLEAR;
      else if (pick >= 70)
         r.operation = uartrb_pkg::OP_READ;
      else if (pick >= 45)
         r.operation = uartrb_pkg::OP_WRITE;
      return r;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // driver: hold a beat until taken, then offer the next or idle
   always @(negedge clock) begin
      if (!reset && (req_taken || !req_valid)) begin
         req_taken = 1'b0;
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= req_backlog.pop_front();
            req_valid <= 1'b1;
         end else
            req_valid <= 1'b0;
      end
   end

   // response side: long hold-off on request, random stall otherwise
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else
         rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // monitor: check responses first, then record the accepted request
   always @(posedge clock) begin
      uartrb_pkg::rsp_type want;
      bit                  moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            moved = 1'b1;
            beats_out++;
            if (owed_rsp.size() == 0) begin
               $error("response beat with nothing expected");
               mismatches++;
            end else begin
               want = owed_rsp.pop_front();
               if (want.tx_send)
                  sends_seen++;
               check_field("tx_send", 16'(want.tx_send), 16'(rsp_data.tx_send));
               check_field("tx_byte", 16'(want.tx_byte), 16'(rsp_data.tx_byte));
               check_field("read_valid", 16'(want.read_valid), 16'(rsp_data.read_valid));
               check_field("read_byte", 16'(want.read_byte), 16'(rsp_data.read_byte));
               check_field("rx_has_data", 16'(want.rx_has_data), 16'(rsp_data.rx_has_data));
               check_field("write_accepted", 16'(want.write_accepted),
                           16'(rsp_data.write_accepted));
               check_field("error_count", want.error_count, rsp_data.error_count);
               check_field("error_led", 16'(want.error_led), 16'(rsp_data.error_led));
               check_field("tx_irq_enable", 16'(want.tx_irq_enable),
                           16'(rsp_data.tx_irq_enable));
            end
         end
         if (req_valid && req_stall === 1'b0) begin
            moved = 1'b1;
            beats_in++;
            want = ring_response(req_data);
            if (req_data.operation == uartrb_pkg::OP_WRITE && !want.write_accepted)
               refused_writes++;
            owed_rsp.push_back(want);
            req_taken = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("simulation failed");
      $finish;
   end

   task automatic drain();
      while (req_backlog.size() != 0 || req_valid || owed_rsp.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_backlog.push_back(make_beat(uartrb_pkg::OP_READ, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_LINE, 1'b0, 8'h00, 1'b0, 1'b1, 8'h00));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_LINE, 1'b1, 8'hFF, 1'b1, 1'b0, 8'hFF));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_WRITE, 1'b1, 8'hFF, 1'b1, 1'b1, 8'hFF));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_WRITE, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_LINE, 1'b0, 8'h00, 1'b0, 1'b1, 8'h00));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_LINE, 1'b1, 8'h00, 1'b0, 1'b1, 8'hFF));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_LINE, 1'b0, 8'h00, 1'b0, 1'b1, 8'h00));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_READ, 1'b1, 8'hFF, 1'b1, 1'b1, 8'hFF));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_READ, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_READ, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_LINE, 1'b1, 8'hA5, 1'b0, 1'b0, 8'h00));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_LINE, 1'b1, 8'h5A, 1'b1, 1'b0, 8'h00));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_CLEAR, 1'b1, 8'hFF, 1'b1, 1'b1, 8'hFF));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_READ, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_CLEAR, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_WRITE, 1'b0, 8'h00, 1'b0, 1'b0, 8'h80));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_LINE, 1'b0, 8'h00, 1'b1, 1'b0, 8'h00));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_LINE, 1'b1, 8'h01, 1'b1, 1'b1, 8'h00));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_READ, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00));
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 65 : (phase == 3) ? 21 : 0;
         stall_pct = (phase == 2) ? 65 : (phase == 3) ? 21 : 0;
         repeat (PHASE_BEATS) req_backlog.push_back(random_beat());
         if (phase == 0)
            hold_req = 1'b1;
         drain();
      end

      // fill the transmit ring past full, drain it through line events until
      // the enable drops, then read back some received bytes
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (TX_SLOTS + 12)
         req_backlog.push_back(make_beat(uartrb_pkg::OP_WRITE, 1'($urandom_range(1)),
                                         8'($urandom_range(255)), 1'($urandom_range(1)),
                                         1'($urandom_range(1)), 8'($urandom_range(255))));
      repeat (TX_SLOTS + 12)
         req_backlog.push_back(make_beat(uartrb_pkg::OP_LINE, 1'($urandom_range(1)),
                                         8'($urandom_range(255)), 1'($urandom_range(1)),
                                         1'b1, 8'($urandom_range(255))));
      repeat (TAIL_READS)
         req_backlog.push_back(make_beat(uartrb_pkg::OP_READ, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_LINE, 1'b1, 8'h3C, 1'b1, 1'b1, 8'h00));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_CLEAR, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00));
      req_backlog.push_back(make_beat(uartrb_pkg::OP_READ, 1'b0, 8'h00, 1'b0, 1'b0, 8'h00));
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (owed_rsp.size() != 0) begin
         $error("%0d expected responses never arrived", owed_rsp.size());
         mismatches++;
      end
      $display("covered %0d request beats and %0d response beats over four idle/stall mixes",
               beats_in, beats_out);
      $display("  %0d line sends, %0d refused writes, error count ended at %0d, %0d mismatches",
               sends_seen, refused_writes, err_tally, mismatches);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
